FILE: rtl/ficu_pkg.sv
// Shared opcodes, stage payload structs and constants for the float/integer
// conversion unit. No dependencies.
package ficu_pkg;
  localparam logic [2:0] OP_F32_U32 = 3'd0;
  localparam logic [2:0] OP_F64_U32 = 3'd1;
  localparam logic [2:0] OP_F64_U64 = 3'd2;
  localparam logic [2:0] OP_S64_F64 = 3'd3;
  localparam logic [2:0] OP_U64_F64 = 3'd4;

  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES32 = 64'h0000_0000_FFFF_FFFF;

  // Decoded word after stage 1.
  typedef struct packed {
    logic        valid;
    logic        is_int;     // integer to double path
    logic        fixed;      // result already known
    logic [63:0] fixed_val;
    logic        left;       // shift left for float path
    logic [6:0]  shamt;
    logic [63:0] mant;       // float mantissa, or integer magnitude
    logic        sign;       // integer sign
  } s1_t;

  // Word after stage 2 (shift / normalize).
  typedef struct packed {
    logic        valid;
    logic        is_int;
    logic        fixed;
    logic [63:0] fixed_val;
    logic [63:0] shifted;    // float path result, or normalized magnitude
    logic [5:0]  lz;
    logic        zero;
    logic        sign;
  } s2_t;
endpackage

FILE: rtl/ficu_decode.sv
// Stage 1: classify operand and compute shift amounts.
// Depends on ficu_pkg.
module ficu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       req_type,
  input  logic [63:0]      operand,
  output ficu_pkg::s1_t    s1
);
  import ficu_pkg::*;
  s1_t nx;
  logic [7:0]  e8;
  logic [10:0] e11;
  logic [63:0] mag;
  always_comb begin
    nx = '0;
    nx.valid = in_valid;
    e8  = operand[30:23];
    e11 = operand[62:52];
    mag = operand;
    unique case (req_type)
      OP_F32_U32: begin
        nx.mant = {40'd0, 1'b1, operand[22:0]};
        if (operand[31]) begin
          nx.fixed = 1'b1;
          nx.fixed_val = (e8 < 8'h7f) ? 64'd0 : ONES32;
        end else if (e8 < 8'h7f) begin
          nx.fixed = 1'b1;
        end else if (e8 > 8'h9e) begin
          nx.fixed = 1'b1;
          nx.fixed_val = ONES32;
        end else if (e8 <= 8'h96) begin
          nx.shamt = 7'(8'h96 - e8);
        end else begin
          nx.left = 1'b1;
          nx.shamt = 7'(e8 - 8'h96);
        end
      end
      OP_F64_U32, OP_F64_U64: begin
        nx.mant = {11'd0, 1'b1, operand[51:0]};
        if (operand[63]) begin
          nx.fixed = 1'b1;
          nx.fixed_val = (e11 < 11'h3ff) ? 64'd0 :
                         (req_type == OP_F64_U64) ? ONES64 : ONES32;
        end else if (e11 < 11'h3ff) begin
          nx.fixed = 1'b1;
        end else if (e11 > ((req_type == OP_F64_U64) ? 11'h43e : 11'h41e)) begin
          nx.fixed = 1'b1;
          nx.fixed_val = (req_type == OP_F64_U64) ? ONES64 : ONES32;
        end else if (e11 <= 11'h433) begin
          nx.shamt = 7'(11'h433 - e11);
        end else begin
          nx.left = 1'b1;
          nx.shamt = 7'(e11 - 11'h433);
        end
      end
      OP_S64_F64, OP_U64_F64: begin
        nx.is_int = 1'b1;
        nx.sign = (req_type == OP_S64_F64) && operand[63];
        if (nx.sign) mag = 64'(~operand + 64'd1);
        nx.mant = mag;
      end
      default: begin
        nx.fixed = 1'b1;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) s1.valid <= 1'b0;
    else s1.valid <= nx.valid;
    s1.is_int <= nx.is_int;
    s1.fixed <= nx.fixed;
    s1.fixed_val <= nx.fixed_val;
    s1.left <= nx.left;
    s1.shamt <= nx.shamt;
    s1.mant <= nx.mant;
    s1.sign <= nx.sign;
  end
endmodule

FILE: rtl/ficu_shift.sv
// Stage 2: float mantissa shift, integer leading-zero count and normalize.
// Depends on ficu_pkg.
module ficu_shift (
  input  logic          clk,
  input  logic          rst,
  input  ficu_pkg::s1_t s1,
  output ficu_pkg::s2_t s2
);
  import ficu_pkg::*;
  s2_t nx;
  logic [5:0] lz;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s1.mant[i]) lz = 6'(63 - i);
    end
    nx = '0;
    nx.valid = s1.valid;
    nx.is_int = s1.is_int;
    nx.fixed = s1.fixed;
    nx.fixed_val = s1.fixed_val;
    nx.sign = s1.sign;
    nx.lz = lz;
    nx.zero = (s1.mant == 64'd0);
    if (s1.is_int) nx.shifted = s1.mant << lz;
    else if (s1.left) nx.shifted = s1.mant << s1.shamt[5:0];
    else nx.shifted = s1.mant >> s1.shamt[5:0];
  end
  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else s2.valid <= nx.valid;
    s2.is_int <= nx.is_int;
    s2.fixed <= nx.fixed;
    s2.fixed_val <= nx.fixed_val;
    s2.shifted <= nx.shifted;
    s2.lz <= nx.lz;
    s2.zero <= nx.zero;
    s2.sign <= nx.sign;
  end
endmodule

FILE: rtl/ficu_round.sv
// Stage 3: round normalized integer to double, select final result.
// Depends on ficu_pkg.
module ficu_round (
  input  logic          clk,
  input  logic          rst,
  input  ficu_pkg::s2_t s2,
  output logic          done,
  output logic [63:0]   result
);
  import ficu_pkg::*;
  logic [52:0] keep;
  logic        g, st, up;
  logic [53:0] sum;
  logic [10:0] ex;
  logic [63:0] dbl, r;
  always_comb begin
    keep = s2.shifted[63:11];
    g = s2.shifted[10];
    st = |s2.shifted[9:0];
    up = g && (st || keep[0]);
    sum = {1'b0, keep} + 54'(up);
    ex = 11'(11'd1086 - {5'd0, s2.lz});
    // carry out of rounding bumps exponent, mantissa wraps to zero
    if (sum[53]) dbl = {s2.sign, 11'(ex + 11'd1), 52'd0};
    else dbl = {s2.sign, ex, sum[51:0]};
    if (s2.zero) dbl = 64'd0;
    if (s2.fixed) r = s2.fixed_val;
    else if (s2.is_int) r = dbl;
    else r = s2.shifted;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s2.valid;
    result <= r;
  end
endmodule

FILE: rtl/float_integer_conversion_unit.sv
// Float/integer conversion unit top level.
// start passes each stage register on its way to done; one word accepted every cycle.
// busy is tied low: the receiver cannot stall, so the pipe always advances.
// Synchronous reset clears the stage valid bits; no result after reset.
// Stages: decode, shift/normalize, round/select. Depends on ficu_pkg.
module float_integer_conversion_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] result
);
  import ficu_pkg::*;
  s1_t s1;
  s2_t s2;
  assign busy = 1'b0;
  ficu_decode u_dec (.clk, .rst, .in_valid(start), .req_type, .operand, .s1);
  ficu_shift  u_sh  (.clk, .rst, .s1, .s2);
  ficu_round  u_rnd (.clk, .rst, .s2, .done, .result);

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 done) else $error("done missing");
  a_nostray: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3)) else $error("stray done");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    s2.valid && s2.is_int && s2.zero |=> result == 64'd0) else $error("zero");
endmodule
